// File: rtl/etcc_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etcc_pkg
// Shared types and constants for the per-EtherType packet and byte counters.
// ----------------------------------------------------------------------------
package etcc_pkg;

  localparam int MAX_CODES_DEF = 15;
  localparam int IDX_W         = 4;
  localparam int CODE_W        = 16;
  localparam int LEN_W         = 16;
  localparam int TIME_W        = 64;
  localparam int BYTE_W        = 64;
  localparam int PKT_W         = 32;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 64;
  localparam int CODES_PER_WORD = 4;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODES_A = 3'd1;

  // command codes
  localparam logic CMD_COUNT = 1'b0;
  localparam logic CMD_DUMP  = 1'b1;

  localparam logic [IDX_W-1:0]      ACTIVE_RST  = 4'd3;
  localparam logic [CFG_DATA_W-1:0] CODES_A_RST = 64'h0000_86DD_0806_0800;

  typedef struct packed {
    logic              command;
    logic              new_interval;
    logic [CODE_W-1:0] ether_type;
    logic [LEN_W-1:0]  packet_length;
    logic [TIME_W-1:0] arrival_time;
  } item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  bucket_index;
    logic [CODE_W-1:0] bucket_code;
    logic [BYTE_W-1:0] byte_total;
    logic [PKT_W-1:0]  packet_total;
    logic [TIME_W-1:0] interval_time;
    logic              last;
  } result_t;

  typedef struct packed {
    logic [BYTE_W-1:0] bytes;
    logic [PKT_W-1:0]  pkts;
  } counters_t;

  // reset value of type code i
  function automatic logic [CODE_W-1:0] code_reset(input int i);
    logic [CODE_W-1:0] val;
    val = '0;
    if (i < CODES_PER_WORD) begin
      val = CODES_A_RST[CODE_W*i +: CODE_W];
    end
    return val;
  endfunction

endpackage
`default_nettype wire

// File: rtl/etcc_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etcc_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module etcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// File: rtl/etcc_classify.sv
`default_nettype none
// ----------------------------------------------------------------------------
// etcc_classify
// Configuration registers, first-match type lookup and bucket code lookup.
// ----------------------------------------------------------------------------
module etcc_classify #(
  parameter int MAX_CODES = etcc_pkg::MAX_CODES_DEF,
  localparam int AW = $clog2(MAX_CODES + 1)
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             cfg_write,
  input  wire logic [etcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [etcc_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  wire logic [etcc_pkg::CODE_W-1:0]      ether_type,
  input  wire logic [AW-1:0]                    rpt_idx,
  output logic      [AW-1:0]                    active,
  output logic      [AW-1:0]                    bucket,
  output logic      [etcc_pkg::CODE_W-1:0]      rpt_code
);

  logic [etcc_pkg::IDX_W-1:0]  active_types;
  logic [etcc_pkg::CODE_W-1:0] code [MAX_CODES];

  always_ff @(posedge clk) begin
    if (rst) begin
      active_types <= etcc_pkg::ACTIVE_RST;
    end else if (cfg_write && cfg_index == etcc_pkg::CFG_ACTIVE) begin
      active_types <= cfg_data[etcc_pkg::IDX_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < MAX_CODES; i++) begin
      if (rst) begin
        code[i] <= etcc_pkg::code_reset(i);
      end else if (cfg_write &&
                   cfg_index == etcc_pkg::CFG_CODES_A + etcc_pkg::CFG_IDX_W'(i >> 2)) begin
        code[i] <= cfg_data[etcc_pkg::CODE_W*(i & 3) +: etcc_pkg::CODE_W];
      end
    end
  end

  assign active = (int'(active_types) > MAX_CODES) ? AW'(MAX_CODES) : AW'(active_types);

  // first match wins: scan from the top so the lowest index is left standing
  always_comb begin
    bucket = active;
    for (int i = MAX_CODES - 1; i >= 0; i--) begin
      if (i < int'(active) && code[i] == ether_type) begin
        bucket = AW'(i);
      end
    end
  end

  always_comb begin
    rpt_code = '0;
    for (int i = 0; i < MAX_CODES; i++) begin
      if (int'(rpt_idx) == i && i < int'(active)) begin
        rpt_code = code[i];
      end
    end
  end

endmodule
`default_nettype wire

// File: rtl/ethertype_class_counters.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ethertype_class_counters
// Per-EtherType packet and byte counters held in a read-modify-write RAM.
// ----------------------------------------------------------------------------
// An item is taken on a clock edge with start high and busy low. A count item
// is classified in its accept cycle, the bucket's counters are read from the
// RAM, and in the next cycle they are updated and written back; a write that
// lands on the entry being read is forwarded, so counts go at one per cycle
// outside a dump. A new-interval count clears every bucket at once through
// per-bucket valid bits (an entry not valid reads as zero) and latches its
// arrival time. A dump reads one bucket per cycle, 0 up to the other bucket,
// and holds busy high after its accept until that bucket is read; each report
// beat appears on result for one cycle with result_strobe, the first behind
// the s1 and result registers, the last with result.last set. The receiver
// cannot stall. Configuration writes are taken every cycle (cfg_ready is
// tied high) and are meant for idle periods only. Reset restores the register
// defaults and clears all counters and the interval time; no clearing pass.
// ----------------------------------------------------------------------------
module ethertype_class_counters #(
  parameter int MAX_CODES = etcc_pkg::MAX_CODES_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire etcc_pkg::item_t                  item,
  output etcc_pkg::result_t                     result,
  output logic                                  result_strobe,
  input  wire logic                             cfg_valid,
  output logic                                  cfg_ready,
  input  wire logic [etcc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [etcc_pkg::CFG_DATA_W-1:0]  cfg_data
);

  localparam int BUCKETS = MAX_CODES + 1;
  localparam int AW      = $clog2(BUCKETS);
  localparam int CNT_W   = etcc_pkg::BYTE_W + etcc_pkg::PKT_W;

  logic                             accept;
  logic                             start_count;
  logic                             start_dump;
  logic                             clear_now;
  logic [AW-1:0]                    active;
  logic [AW-1:0]                    bucket;
  logic [etcc_pkg::CODE_W-1:0]      rpt_code;

  logic                             dump_active;
  logic [AW-1:0]                    dump_idx;
  logic [AW-1:0]                    rd_addr;
  logic                             rd_last;

  logic                             s1_count;
  logic                             s1_rpt;
  logic                             s1_last;
  logic [AW-1:0]                    s1_addr;
  logic [etcc_pkg::LEN_W-1:0]       s1_len;

  logic [BUCKETS-1:0]               valid;
  logic                             fwd_valid;
  logic [AW-1:0]                    fwd_addr;
  etcc_pkg::counters_t              fwd_data;
  etcc_pkg::counters_t              ram_q;
  etcc_pkg::counters_t              cur;
  etcc_pkg::counters_t              upd;
  logic [etcc_pkg::TIME_W-1:0]      interval_stamp;

  assign cfg_ready   = 1'b1;
  assign busy        = dump_active;
  assign accept      = start && !busy;
  assign start_count = accept && item.command == etcc_pkg::CMD_COUNT;
  assign start_dump  = accept && item.command == etcc_pkg::CMD_DUMP;
  assign clear_now   = start_count && item.new_interval;

  etcc_classify #(
    .MAX_CODES(MAX_CODES)
  ) u_classify (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ether_type(item.ether_type),
    .rpt_idx   (s1_addr),
    .active    (active),
    .bucket    (bucket),
    .rpt_code  (rpt_code)
  );

  // read address: dump sequencer, then a dump's first bucket, then a count
  always_comb begin
    if (dump_active) begin
      rd_addr = dump_idx;
    end else if (start_dump) begin
      rd_addr = '0;
    end else begin
      rd_addr = bucket;
    end
    rd_last = (rd_addr == active);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dump_active <= 1'b0;
      dump_idx    <= '0;
    end else if (dump_active) begin
      dump_idx <= dump_idx + AW'(1);
      if (dump_idx == active) begin
        dump_active <= 1'b0;
      end
    end else if (start_dump && active != '0) begin
      dump_active <= 1'b1;
      dump_idx    <= AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_count <= 1'b0;
      s1_rpt   <= 1'b0;
    end else begin
      s1_count <= start_count;
      s1_rpt   <= dump_active || start_dump;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= rd_addr;
    s1_last <= rd_last;
    s1_len  <= item.packet_length;
  end

  etcc_ram #(
    .WIDTH(CNT_W),
    .DEPTH(BUCKETS)
  ) u_counters (
    .clk    (clk),
    .wr_en  (s1_count),
    .wr_addr(s1_addr),
    .wr_data(upd),
    .rd_addr(rd_addr),
    .rd_data(ram_q)
  );

  // forwarded write from the cycle the read was issued, else the RAM word
  always_comb begin
    if (fwd_valid && fwd_addr == s1_addr) begin
      cur = fwd_data;
    end else if (valid[s1_addr]) begin
      cur = ram_q;
    end else begin
      cur = '0;
    end
    upd.bytes = cur.bytes + etcc_pkg::BYTE_W'(s1_len);
    upd.pkts  = cur.pkts + etcc_pkg::PKT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid     <= '0;
      fwd_valid <= 1'b0;
    end else begin
      fwd_valid <= s1_count && !clear_now;
      if (clear_now) begin
        valid <= '0;
      end else if (s1_count) begin
        valid[s1_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    fwd_addr <= s1_addr;
    fwd_data <= upd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      interval_stamp <= '0;
    end else if (clear_now) begin
      interval_stamp <= item.arrival_time;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= s1_rpt;
    end
  end

  always_ff @(posedge clk) begin
    result.bucket_index  <= etcc_pkg::IDX_W'(s1_addr);
    result.bucket_code   <= rpt_code;
    result.byte_total    <= cur.bytes;
    result.packet_total  <= cur.pkts;
    result.interval_time <= interval_stamp;
    result.last          <= s1_last;
  end

`ifndef SYNTH
  a_dump_idx_range: assert property (@(posedge clk) disable iff (rst)
    dump_active |-> (dump_idx != '0 && dump_idx <= active))
    else $error("dump index out of range");

  a_clear_valid: assert property (@(posedge clk) disable iff (rst)
    clear_now |=> valid == '0)
    else $error("valid bits not cleared by new interval");

  a_dump_busy: assert property (@(posedge clk) disable iff (rst)
    (start_dump && active != '0) |=> busy)
    else $error("multi-bucket dump did not raise busy");

  a_last_bucket: assert property (@(posedge clk) disable iff (rst)
    (result_strobe && result.last) |-> result.bucket_index == etcc_pkg::IDX_W'(active))
    else $error("last beat not on the other bucket");
`endif

endmodule
`default_nettype wire
